// ===== rtl/threshold_run_interval_detector_assert.svh =====
// Assertion macros used by the top-level detector RTL.
`ifndef THRESHOLD_RUN_INTERVAL_DETECTOR_ASSERT_SVH
`define THRESHOLD_RUN_INTERVAL_DETECTOR_ASSERT_SVH

// Same-cycle implication, clocked on aclk, off during reset.
`define TRID_ASSERT_IMP(label, ante, cons) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error("trid: implication check failed");

// Next-cycle implication, clocked on aclk, off during reset.
`define TRID_ASSERT_NXT(label, ante, cons) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error("trid: next-cycle check failed");

`endif

// ===== rtl/trid_pkg.sv =====
// ----------------------------------------------------------------------------
// trid_pkg
// Types, constants and register map of the threshold run interval detector.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package trid_pkg;

    localparam int CHANNELS = 64;
    localparam int CH_W     = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;

    localparam int APB_AW = 3;
    localparam int APB_DW = 32;

    localparam logic [30:0] MIN_ERROR_RST  = 31'd655;
    localparam logic [31:0] MIN_LENGTH_RST = 32'd5;

    typedef enum logic [0:0] {
        REG_MIN_ERROR  = 1'b0,
        REG_MIN_LENGTH = 1'b1
    } reg_idx_t;

    typedef logic [CH_W-1:0] ch_idx_t;

    typedef struct packed {
        logic [5:0]         channel;
        logic signed [31:0] error_value;
        logic [31:0]        position;
        logic               stream_last;
    } in_item_t;

    typedef struct packed {
        logic [5:0]  run_channel;
        logic [31:0] run_start;
        logic [31:0] run_end;
    } out_item_t;

    typedef struct packed {
        logic [30:0] min_error;
        logic [31:0] min_length;
    } cfg_t;

    typedef struct packed {
        logic        start_we;
        logic        end_we;
        logic        active_we;
        logic        active_val;
        ch_idx_t     ch;
        logic [31:0] pos;
    } store_wr_t;

    typedef struct packed {
        logic        active;
        logic [31:0] start_pos;
        logic [31:0] end_pos;
    } store_rd_t;

endpackage

// ===== rtl/trid_apb_regs.sv =====
// ----------------------------------------------------------------------------
// trid_apb_regs
// APB register file holding the error threshold and the minimum run length.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module trid_apb_regs (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [trid_pkg::APB_AW-1:0]   paddr,
    input  logic [trid_pkg::APB_DW-1:0]   pwdata,
    output logic [trid_pkg::APB_DW-1:0]   prdata,
    output logic                          pready,
    output trid_pkg::cfg_t                cfg
);
    import trid_pkg::*;

    cfg_t     cfg_reg;
    cfg_t     cfg_next;
    reg_idx_t idx;
    logic     wr_en;

    assign pready = 1'b1;
    assign idx    = reg_idx_t'(paddr[2]);
    assign wr_en  = psel && penable && pwrite && pready;

    always_comb begin
        cfg_next = cfg_reg;
        if (wr_en) begin
            unique case (idx)
                REG_MIN_ERROR:  cfg_next.min_error  = pwdata[30:0];
                REG_MIN_LENGTH: cfg_next.min_length = pwdata;
                default: ;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.min_error  <= MIN_ERROR_RST;
            cfg_reg.min_length <= MIN_LENGTH_RST;
        end else begin
            cfg_reg <= cfg_next;
        end
    end

    always_comb begin
        unique case (idx)
            REG_MIN_ERROR:  prdata = {1'b0, cfg_reg.min_error};
            REG_MIN_LENGTH: prdata = cfg_reg.min_length;
            default:        prdata = '0;
        endcase
    end

    assign cfg = cfg_reg;

endmodule

// ===== rtl/trid_run_store.sv =====
// ----------------------------------------------------------------------------
// trid_run_store
// Per-channel run state: active flags, start and end position memories.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module trid_run_store (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 rd_en,
    input  trid_pkg::ch_idx_t    rd_ch,
    input  trid_pkg::ch_idx_t    look_ch,
    input  trid_pkg::store_wr_t  wr,
    output trid_pkg::store_rd_t  rd
);
    import trid_pkg::*;

    logic [31:0]         start_mem [CHANNELS];
    logic [31:0]         end_mem   [CHANNELS];
    logic [31:0]         start_rd_reg;
    logic [31:0]         end_rd_reg;
    logic [CHANNELS-1:0] active_reg;

    always_ff @(posedge aclk) begin
        if (wr.start_we) begin
            start_mem[wr.ch] <= wr.pos;
        end
        if (wr.end_we) begin
            end_mem[wr.ch] <= wr.pos;
        end
    end

    // forward a write landing on the channel being read
    always_ff @(posedge aclk) begin
        if (rd_en) begin
            if (wr.start_we && wr.ch == rd_ch) begin
                start_rd_reg <= wr.pos;
            end else begin
                start_rd_reg <= start_mem[rd_ch];
            end
            if (wr.end_we && wr.ch == rd_ch) begin
                end_rd_reg <= wr.pos;
            end else begin
                end_rd_reg <= end_mem[rd_ch];
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            active_reg <= '0;
        end else if (wr.active_we) begin
            active_reg[wr.ch] <= wr.active_val;
        end
    end

    assign rd.active    = active_reg[look_ch];
    assign rd.start_pos = start_rd_reg;
    assign rd.end_pos   = end_rd_reg;

endmodule

// ===== rtl/trid_run_eval.sv =====
// ----------------------------------------------------------------------------
// trid_run_eval
// Threshold compare, run open/extend/close decision and report qualification.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module trid_run_eval (
    input  logic                 go,
    input  trid_pkg::in_item_t   item,
    input  trid_pkg::store_rd_t  rd,
    input  trid_pkg::cfg_t       cfg,
    output trid_pkg::ch_idx_t    idx,
    output trid_pkg::store_wr_t  wr,
    output logic                 res_valid,
    output trid_pkg::out_item_t  res
);
    import trid_pkg::*;

    logic        in_range;
    logic [31:0] err_raw;
    logic [31:0] mag;
    logic        high;
    logic        close;
    logic [31:0] end_pos;
    logic [31:0] span;
    logic        long_enough;
    logic        en;

    assign idx      = item.channel[CH_W-1:0];
    assign in_range = 32'(item.channel) < 32'(CHANNELS);
    assign en       = go && in_range;

    assign err_raw = item.error_value;
    assign mag     = err_raw[31] ? (32'd0 - err_raw) : err_raw;
    assign high    = mag >= {1'b0, cfg.min_error};

    assign close   = !high || item.stream_last;
    assign end_pos = high ? item.position : rd.end_pos;
    assign span    = end_pos - rd.start_pos;
    assign long_enough = (end_pos >= rd.start_pos) && (span >= cfg.min_length);

    always_comb begin
        wr.ch         = idx;
        wr.pos        = item.position;
        wr.start_we   = en && !rd.active && high;
        wr.end_we     = en && high;
        wr.active_we  = en && (rd.active ? close : high);
        wr.active_val = !rd.active;
    end

    assign res_valid       = en && rd.active && close && long_enough;
    assign res.run_channel = item.channel;
    assign res.run_start   = rd.start_pos;
    assign res.run_end     = end_pos;

endmodule

// ===== rtl/threshold_run_interval_detector.sv =====
// ----------------------------------------------------------------------------
// threshold_run_interval_detector
// Per-channel error run detector with minimum-length reporting.
// ----------------------------------------------------------------------------
// Samples enter on the s_ channel (valid/ready, payload struct in_item_t):
// channel, signed Q16.16 error, position and end-of-stream flag. Completed
// runs leave on the m_ channel as channel, start and end (out_item_t).
// Threshold and minimum length sit in APB registers at 0x0 and 0x4.
// Throughput: one sample per cycle unless m_ready stalls a full output register;
// the per-channel start/end memories are read-modify-written, with write-to-read
// forwarding for back-to-back samples of the same channel.
// A result from the transaction that closed the run reaches m_valid via the
// memory read and sample capture on accept, then evaluate into the output
// register.
// Samples that close no qualifying run produce no result.
// Reset clears all active flags and restores the register defaults; the
// position memories need no clearing and the block is ready right away.
// When m_valid is high and m_ready is low the output register holds; the sample
// stage keeps accepting until it also fills, then s_ready drops.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

`include "threshold_run_interval_detector_assert.svh"

module threshold_run_interval_detector (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          s_valid,
    output logic                          s_ready,
    input  trid_pkg::in_item_t            s_payload,
    output logic                          m_valid,
    input  logic                          m_ready,
    output trid_pkg::out_item_t           m_payload,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [trid_pkg::APB_AW-1:0]   paddr,
    input  logic [trid_pkg::APB_DW-1:0]   pwdata,
    output logic [trid_pkg::APB_DW-1:0]   prdata,
    output logic                          pready
);
    import trid_pkg::*;

    cfg_t      cfg;
    logic      accept;
    logic      advance;
    logic      st_fire;
    logic      st_valid_reg;
    logic      st_valid_next;
    in_item_t  st_item_reg;
    logic      m_valid_reg;
    logic      m_valid_next;
    out_item_t m_payload_reg;
    ch_idx_t   st_idx;
    store_wr_t wr;
    store_rd_t rd;
    logic      res_valid;
    out_item_t res;

    trid_apb_regs u_regs (
        .aclk    (aclk),
        .aresetn (aresetn),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    assign advance = !m_valid_reg || m_ready;
    assign s_ready = !st_valid_reg || advance;
    assign accept  = s_valid && s_ready;
    assign st_fire = st_valid_reg && advance;

    trid_run_store u_store (
        .aclk    (aclk),
        .aresetn (aresetn),
        .rd_en   (accept),
        .rd_ch   (s_payload.channel[CH_W-1:0]),
        .look_ch (st_idx),
        .wr      (wr),
        .rd      (rd)
    );

    trid_run_eval u_eval (
        .go        (st_fire),
        .item      (st_item_reg),
        .rd        (rd),
        .cfg       (cfg),
        .idx       (st_idx),
        .wr        (wr),
        .res_valid (res_valid),
        .res       (res)
    );

    always_comb begin
        st_valid_next = st_valid_reg;
        if (accept) begin
            st_valid_next = 1'b1;
        end else if (st_fire) begin
            st_valid_next = 1'b0;
        end
        m_valid_next = advance ? res_valid : m_valid_reg;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            st_valid_reg <= 1'b0;
            m_valid_reg  <= 1'b0;
        end else begin
            st_valid_reg <= st_valid_next;
            m_valid_reg  <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            st_item_reg <= s_payload;
        end
        if (advance && res_valid) begin
            m_payload_reg <= res;
        end
    end

    assign m_valid   = m_valid_reg;
    assign m_payload = m_payload_reg;

    `TRID_ASSERT_IMP(a_run_ordered, m_valid, m_payload.run_end >= m_payload.run_start)
    `TRID_ASSERT_IMP(a_backpressure, st_valid_reg && m_valid && !m_ready, !s_ready)
    `TRID_ASSERT_NXT(a_result_from_stage, !m_valid && !st_valid_reg, !m_valid)
    `TRID_ASSERT_IMP(a_no_stage_write, !st_fire, !wr.start_we && !wr.end_we && !wr.active_we)

endmodule
